/* src/rpcc_pkg.sv */
`timescale 1ns / 1ps
package rpcc_pkg;

	localparam int MAX_LENGTH_DEF = 1024;
	localparam int MAX_COVARI_DEF = 16;
	localparam int MAX_FORBID_DEF = 16;

	localparam int POS_W  = 10;
	localparam int SLOT_W = 4;
	localparam int BASE_W = 3;
	localparam int CNT_CFG_W = 5;
	localparam int LEN_CFG_W = 11;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	localparam logic [BASE_W-1:0] BASE_A     = 3'd0;
	localparam logic [BASE_W-1:0] BASE_C     = 3'd1;
	localparam logic [BASE_W-1:0] BASE_G     = 3'd2;
	localparam logic [BASE_W-1:0] BASE_U     = 3'd3;
	localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;

	typedef enum logic [1:0] {
		OP_LOAD_BASE   = 2'd0,
		OP_LOAD_COVARI = 2'd1,
		OP_LOAD_FORBID = 2'd2,
		OP_QUERY       = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		REG_MIN_DIST   = 3'd0,
		REG_MAX_DIST   = 3'd1,
		REG_SEQ_LEN    = 3'd2,
		REG_FORBID_GU  = 3'd3,
		REG_ALLOW_PK   = 3'd4,
		REG_COVARI_CNT = 3'd5,
		REG_FORBID_CNT = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic [POS_W-1:0]     min_pair_dist;
		logic [POS_W-1:0]     max_pair_dist;
		logic [LEN_CFG_W-1:0] seq_length;
		logic                 forbid_gu;
		logic                 allow_pseudoknot;
		logic [CNT_CFG_W-1:0] covari_count;
		logic [CNT_CFG_W-1:0] forbid_count;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic decided;
		logic verdict;
	} scan_rsp_t;

	function automatic logic bases_pair(logic [BASE_W-1:0] o, logic [BASE_W-1:0] c,
			logic forbid_gu);
		logic wc;
		logic gu;
		wc = (o == BASE_A && c == BASE_U) || (o == BASE_C && c == BASE_G) ||
			(o == BASE_G && c == BASE_C) || (o == BASE_U && c == BASE_A);
		gu = (o == BASE_G && c == BASE_U) || (o == BASE_U && c == BASE_G);
		return wc || (gu && !forbid_gu);
	endfunction

endpackage

/* src/rpcc_cfg_regs.sv */
`timescale 1ns / 1ps
module rpcc_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpcc_pkg::PADDR_W-1:0] paddr,
	input  logic [rpcc_pkg::PDATA_W-1:0] pwdata,
	output logic [rpcc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready,
	output rpcc_pkg::cfg_t               cfg
);
	import rpcc_pkg::*;

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[4:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_pair_dist    <= POS_W'(3);
			cfg_q.max_pair_dist    <= POS_W'(1023);
			cfg_q.seq_length       <= '0;
			cfg_q.forbid_gu        <= 1'b0;
			cfg_q.allow_pseudoknot <= 1'b0;
			cfg_q.covari_count     <= '0;
			cfg_q.forbid_count     <= '0;
		end else if (wr_en) begin
			case (idx)
				REG_MIN_DIST:   cfg_q.min_pair_dist    <= pwdata[POS_W-1:0];
				REG_MAX_DIST:   cfg_q.max_pair_dist    <= pwdata[POS_W-1:0];
				REG_SEQ_LEN:    cfg_q.seq_length       <= pwdata[LEN_CFG_W-1:0];
				REG_FORBID_GU:  cfg_q.forbid_gu        <= pwdata[0];
				REG_ALLOW_PK:   cfg_q.allow_pseudoknot <= pwdata[0];
				REG_COVARI_CNT: cfg_q.covari_count     <= pwdata[CNT_CFG_W-1:0];
				REG_FORBID_CNT: cfg_q.forbid_count     <= pwdata[CNT_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_MIN_DIST:   prdata = PDATA_W'(cfg_q.min_pair_dist);
			REG_MAX_DIST:   prdata = PDATA_W'(cfg_q.max_pair_dist);
			REG_SEQ_LEN:    prdata = PDATA_W'(cfg_q.seq_length);
			REG_FORBID_GU:  prdata = PDATA_W'(cfg_q.forbid_gu);
			REG_ALLOW_PK:   prdata = PDATA_W'(cfg_q.allow_pseudoknot);
			REG_COVARI_CNT: prdata = PDATA_W'(cfg_q.covari_count);
			REG_FORBID_CNT: prdata = PDATA_W'(cfg_q.forbid_count);
			default:        prdata = '0;
		endcase
	end

endmodule

/* src/rpcc_base_mem.sv */
`timescale 1ns / 1ps
module rpcc_base_mem #(
	parameter int MAX_LENGTH = rpcc_pkg::MAX_LENGTH_DEF
) (
	input  logic                        clk,
	input  logic                        wr_en,
	input  logic [rpcc_pkg::POS_W-1:0]  wr_pos,
	input  logic [rpcc_pkg::BASE_W-1:0] wr_base,
	input  logic                        rd_en,
	input  logic [rpcc_pkg::POS_W-1:0]  rd_row_pos,
	input  logic [rpcc_pkg::POS_W-1:0]  rd_col_pos,
	output logic [rpcc_pkg::BASE_W-1:0] rd_row_base,
	output logic [rpcc_pkg::BASE_W-1:0] rd_col_base
);
	import rpcc_pkg::*;

	localparam int AW = $clog2(MAX_LENGTH);

	logic [BASE_W-1:0] mem [MAX_LENGTH];
	logic [BASE_W-1:0] row_data_s1;
	logic [BASE_W-1:0] col_data_s1;
	logic              row_oob_s1;
	logic              col_oob_s1;

	// Positions past the end of the store read as a base that never pairs.
	always_ff @(posedge clk) begin
		if (wr_en && (32'(wr_pos) < MAX_LENGTH)) begin
			mem[AW'(wr_pos)] <= wr_base;
		end
		if (rd_en) begin
			row_data_s1 <= mem[AW'(rd_row_pos)];
			col_data_s1 <= mem[AW'(rd_col_pos)];
			row_oob_s1  <= 32'(rd_row_pos) >= MAX_LENGTH;
			col_oob_s1  <= 32'(rd_col_pos) >= MAX_LENGTH;
		end
	end

	assign rd_row_base = row_oob_s1 ? BASE_OTHER : row_data_s1;
	assign rd_col_base = col_oob_s1 ? BASE_OTHER : col_data_s1;

endmodule

/* src/rpcc_list_scan.sv */
`timescale 1ns / 1ps
module rpcc_list_scan #(
	parameter int MAX_COVARI = rpcc_pkg::MAX_COVARI_DEF,
	parameter int MAX_FORBID = rpcc_pkg::MAX_FORBID_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cov_wr_en,
	input  logic                           forb_wr_en,
	input  logic [rpcc_pkg::SLOT_W-1:0]    wr_slot,
	input  logic [rpcc_pkg::POS_W-1:0]     wr_position,
	input  logic [rpcc_pkg::POS_W-1:0]     wr_partner,
	input  logic                           start,
	input  logic [rpcc_pkg::POS_W-1:0]     row,
	input  logic [rpcc_pkg::POS_W-1:0]     col,
	input  logic                           allow_pseudoknot,
	input  logic [rpcc_pkg::CNT_CFG_W-1:0] covari_count,
	input  logic [rpcc_pkg::CNT_CFG_W-1:0] forbid_count,
	output rpcc_pkg::scan_rsp_t            rsp
);
	import rpcc_pkg::*;

	localparam int LIST_DEPTH = MAX_COVARI + MAX_FORBID;
	localparam int LIST_AW    = $clog2(LIST_DEPTH);
	localparam int CNT_W      = $clog2(LIST_DEPTH + 1);
	localparam int ENT_W      = 2 * POS_W;

	// Covariation pairs occupy the low entries, forbidden positions follow.
	logic [ENT_W-1:0]   mem [LIST_DEPTH];
	logic [ENT_W-1:0]   data_s1;
	logic               kind_cov_s1;
	logic               valid_s1;
	logic [CNT_W-1:0]   k_q;
	logic [CNT_W-1:0]   n_cov_q;
	logic [CNT_W-1:0]   total_q;
	logic               active_q;
	scan_rsp_t          rsp_q;

	logic [CNT_W-1:0]   n_cov;
	logic [CNT_W-1:0]   n_forb;
	logic [CNT_W-1:0]   rd_idx;
	logic [LIST_AW-1:0] wr_addr;
	logic               wr_en;
	logic               rd_en;
	logic [POS_W-1:0]   ent_open;
	logic [POS_W-1:0]   ent_close;
	logic [POS_W-1:0]   lo;
	logic [POS_W-1:0]   hi;
	logic               row_in;
	logic               row_out;
	logic               col_in;
	logic               col_out;
	logic               hit;
	logic               verdict;

	assign n_cov  = (32'(covari_count) > MAX_COVARI) ? CNT_W'(MAX_COVARI)
		: CNT_W'(covari_count);
	assign n_forb = (32'(forbid_count) > MAX_FORBID) ? CNT_W'(MAX_FORBID)
		: CNT_W'(forbid_count);

	// Covariation entries are visited from the last one down.
	assign rd_idx = (k_q < n_cov_q) ? (n_cov_q - CNT_W'(1) - k_q)
		: (CNT_W'(MAX_COVARI) + k_q - n_cov_q);
	assign rd_en  = active_q && (k_q < total_q);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = LIST_AW'(wr_slot);
		if (cov_wr_en && (32'(wr_slot) < MAX_COVARI)) begin
			wr_en = 1'b1;
		end else if (forb_wr_en && (32'(wr_slot) < MAX_FORBID)) begin
			wr_en   = 1'b1;
			wr_addr = LIST_AW'(MAX_COVARI) + LIST_AW'(wr_slot);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= {wr_position, wr_partner};
		end
		if (rd_en) begin
			data_s1     <= mem[LIST_AW'(rd_idx)];
			kind_cov_s1 <= k_q < n_cov_q;
		end
	end

	assign ent_open  = data_s1[ENT_W-1:POS_W];
	assign ent_close = data_s1[POS_W-1:0];
	assign lo        = (ent_open < ent_close) ? ent_open : ent_close;
	assign hi        = (ent_open < ent_close) ? ent_close : ent_open;
	assign row_in    = (row > lo) && (row < hi);
	assign row_out   = (row < lo) || (row > hi);
	assign col_in    = (col > lo) && (col < hi);
	assign col_out   = (col < lo) || (col > hi);

	always_comb begin
		hit     = 1'b0;
		verdict = 1'b0;
		if (kind_cov_s1) begin
			if (row == ent_open && col == ent_close) begin
				hit     = 1'b1;
				verdict = 1'b1;
			end else if (row == ent_open || col == ent_close || row == ent_close ||
					col == ent_open) begin
				hit = 1'b1;
			end else if (!allow_pseudoknot && ((row_out && col_in) || (row_in && col_out))) begin
				hit = 1'b1;
			end
		end else begin
			// Only the position in the upper half of a forbidden entry is used.
			hit = (row == ent_open) || (col == ent_open);
		end
		hit = hit && valid_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			valid_s1 <= 1'b0;
			k_q      <= '0;
			n_cov_q  <= '0;
			total_q  <= '0;
			rsp_q    <= '0;
		end else begin
			rsp_q.done <= 1'b0;
			if (start) begin
				active_q <= 1'b1;
				valid_s1 <= 1'b0;
				k_q      <= '0;
				n_cov_q  <= n_cov;
				total_q  <= n_cov + n_forb;
			end else if (active_q) begin
				if (hit) begin
					active_q      <= 1'b0;
					valid_s1      <= 1'b0;
					rsp_q.done    <= 1'b1;
					rsp_q.decided <= 1'b1;
					rsp_q.verdict <= verdict;
				end else if (k_q < total_q) begin
					valid_s1 <= 1'b1;
					k_q      <= k_q + CNT_W'(1);
				end else begin
					active_q      <= 1'b0;
					valid_s1      <= 1'b0;
					rsp_q.done    <= 1'b1;
					rsp_q.decided <= 1'b0;
					rsp_q.verdict <= 1'b0;
				end
			end
		end
	end

	assign rsp = rsp_q;

	a_done_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_q.done |-> !active_q)
		else $error("scan still active after its response");
	a_valid_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> active_q)
		else $error("entry under evaluation outside a scan");
	a_index_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (k_q <= total_q))
		else $error("scan index ran past the entry count");

endmodule

/* src/rna_pair_constraint_check_top.sv */
`timescale 1ns / 1ps
// RNA base-pair constraint checker.
// Items arrive on start with op, position, partner, slot and base; a transfer
// happens at a clock edge where start is high and busy is low. Loads of a base,
// a covariation pair or a forbidden position produce no result and leave busy
// low, so loads may be issued every cycle while no query is running.
// A query (op 3, row in position, column in partner) raises busy and returns
// can_pair with done high for exactly one cycle. The query first checks the
// distance window, then walks the list memory one entry per cycle:
// the valid covariation entries from the last down, then the forbidden ones.
// A query ends early when an entry settles the answer, and goes straight to
// its result after the window check when the column is outside the window.
// A new item is taken in the cycle in which done is high.
// Registers sit on the APB-style port at byte address 4*index; writes complete
// with no wait states and should be made while no query is running.
// Reset clears the registers to their defaults and returns the block to idle;
// the sequence and list memories are not cleared and hold no valid data until
// loaded. The receiver cannot stall: each result is shown for one cycle only.
module rna_pair_constraint_check_top #(
	parameter int MAX_LENGTH = rpcc_pkg::MAX_LENGTH_DEF,
	parameter int MAX_COVARI = rpcc_pkg::MAX_COVARI_DEF,
	parameter int MAX_FORBID = rpcc_pkg::MAX_FORBID_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   op,
	input  logic [rpcc_pkg::POS_W-1:0]   position,
	input  logic [rpcc_pkg::POS_W-1:0]   partner,
	input  logic [rpcc_pkg::SLOT_W-1:0]  slot,
	input  logic [rpcc_pkg::BASE_W-1:0]  base,
	output logic                         can_pair,
	output logic                         done,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [rpcc_pkg::PADDR_W-1:0] paddr,
	input  logic [rpcc_pkg::PDATA_W-1:0] pwdata,
	output logic [rpcc_pkg::PDATA_W-1:0] prdata,
	output logic                         pready
);
	import rpcc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WIN,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic             done_q;
	logic             can_pair_q;
	logic             scan_start_q;
	logic [POS_W-1:0] row_q;
	logic [POS_W-1:0] col_q;

	cfg_t             cfg;
	scan_rsp_t        scan_rsp;
	op_t              op_in;
	logic             accept;
	logic             query_acc;
	logic [BASE_W-1:0] row_base;
	logic [BASE_W-1:0] col_base;
	logic [POS_W+1:0] lower_bound;
	logic [POS_W+1:0] upper_raw;
	logic [POS_W+1:0] upper_bound;
	logic             in_window;

	assign op_in     = op_t'(op);
	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign query_acc = accept && (op_in == OP_QUERY);

	rpcc_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	rpcc_base_mem #(
		.MAX_LENGTH (MAX_LENGTH)
	) u_base_mem (
		.clk         (clk),
		.wr_en       (accept && (op_in == OP_LOAD_BASE)),
		.wr_pos      (position),
		.wr_base     (base),
		.rd_en       (query_acc),
		.rd_row_pos  (position),
		.rd_col_pos  (partner),
		.rd_row_base (row_base),
		.rd_col_base (col_base)
	);

	rpcc_list_scan #(
		.MAX_COVARI (MAX_COVARI),
		.MAX_FORBID (MAX_FORBID)
	) u_list_scan (
		.clk              (clk),
		.arst_n           (arst_n),
		.cov_wr_en        (accept && (op_in == OP_LOAD_COVARI)),
		.forb_wr_en       (accept && (op_in == OP_LOAD_FORBID)),
		.wr_slot          (slot),
		.wr_position      (position),
		.wr_partner       (partner),
		.start            (scan_start_q),
		.row              (row_q),
		.col              (col_q),
		.allow_pseudoknot (cfg.allow_pseudoknot),
		.covari_count     (cfg.covari_count),
		.forbid_count     (cfg.forbid_count),
		.rsp              (scan_rsp)
	);

	always_ff @(posedge clk) begin
		if (query_acc) begin
			row_q <= position;
			col_q <= partner;
		end
	end

	// The upper bound is clipped to the sequence length.
	assign lower_bound = (POS_W+2)'(row_q) + (POS_W+2)'(cfg.min_pair_dist) + (POS_W+2)'(1);
	assign upper_raw   = (POS_W+2)'(row_q) + (POS_W+2)'(cfg.max_pair_dist) + (POS_W+2)'(2);
	assign upper_bound = (upper_raw > (POS_W+2)'(cfg.seq_length)) ?
		(POS_W+2)'(cfg.seq_length) : upper_raw;
	assign in_window   = ((POS_W+2)'(col_q) >= lower_bound) &&
		((POS_W+2)'(col_q) < upper_bound);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			done_q       <= 1'b0;
			can_pair_q   <= 1'b0;
			scan_start_q <= 1'b0;
		end else begin
			done_q       <= 1'b0;
			scan_start_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (query_acc) begin
						state_q <= ST_WIN;
					end
				end
				ST_WIN: begin
					if (in_window) begin
						scan_start_q <= 1'b1;
						state_q      <= ST_SCAN;
					end else begin
						done_q     <= 1'b1;
						can_pair_q <= 1'b0;
						state_q    <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (scan_rsp.done) begin
						done_q     <= 1'b1;
						can_pair_q <= scan_rsp.decided ? scan_rsp.verdict
							: bases_pair(row_base, col_base, cfg.forbid_gu);
						state_q    <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign done     = done_q;
	assign can_pair = can_pair_q;

	a_single_strobe: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("result strobe held for more than one cycle");
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		query_acc |=> busy)
		else $error("query transfer did not raise busy");
	a_busy_ends_with_result: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done_q)
		else $error("query finished without a result");

endmodule

/* tb/tb_rna_pair_constraint_check_top.sv */
`timescale 1ns / 1ps
module tb_rna_pair_constraint_check_top;
	import rpcc_pkg::*;

	localparam int N_PHASES        = 8;
	localparam int ITEMS_PER_PHASE = 110;
	localparam int SETTLE_CYCLES   = 3;
	localparam int END_WAIT        = 40;
	localparam int STALL_LIMIT     = 3000;
	localparam int N_DIRECTED      = 39;

	localparam bit ROW_CFG  = 1'b1;
	localparam bit ROW_ITEM = 1'b0;
	localparam bit TYPED    = 1'b1;
	localparam bit PRED     = 1'b0;

	typedef struct {
		bit                is_cfg;
		reg_idx_t          idx;
		logic [31:0]       val;
		op_t               opc;
		logic [POS_W-1:0]  pos;
		logic [POS_W-1:0]  par;
		logic [SLOT_W-1:0] slt;
		logic [BASE_W-1:0] bse;
		bit                typed;
		bit                texp;
	} dir_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [1:0]           op;
	logic [POS_W-1:0]     position;
	logic [POS_W-1:0]     partner;
	logic [SLOT_W-1:0]    slot;
	logic [BASE_W-1:0]    base;
	logic                 can_pair;
	logic                 done;
	logic                 psel;
	logic                 penable;
	logic                 pwrite;
	logic [PADDR_W-1:0]   paddr;
	logic [PDATA_W-1:0]   pwdata;
	logic [PDATA_W-1:0]   prdata;
	logic                 pready;

	rna_pair_constraint_check_top uut (
		.clk, .arst_n, .start, .busy, .op, .position, .partner, .slot, .base,
		.can_pair, .done, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	// Shadow copy of the block's contents and registers.
	logic [BASE_W-1:0] base_mem [MAX_LENGTH_DEF];
	logic [POS_W-1:0]  cov_open_mem [MAX_COVARI_DEF];
	logic [POS_W-1:0]  cov_close_mem [MAX_COVARI_DEF];
	logic [POS_W-1:0]  forbid_mem [MAX_FORBID_DEF];
	cfg_t              cfg_shadow;

	logic        pair_expect_q [$];
	logic        oldest_pair;
	bit          offering;
	int          err_cnt;
	int          stall_cycles;
	int          loaded_len;
	int          cur_lr;
	int          cur_min;
	int unsigned n_loads;
	int unsigned n_queries;
	int unsigned n_ones;
	int unsigned n_writes;

	localparam logic [BASE_W-1:0] SEED_BASES [16] = '{
		BASE_G, BASE_G, BASE_A, BASE_C, BASE_A, BASE_U, BASE_U, BASE_C,
		BASE_C, BASE_G, BASE_U, BASE_A, BASE_G, BASE_C, BASE_U, 3'd7
	};

	dir_row_t dir_tab [N_DIRECTED] = '{
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd4, 4'd0, 3'd0, TYPED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd1023, 10'd1023, 4'd15, 3'd7, TYPED, 1'b0},
		'{ROW_CFG, REG_SEQ_LEN, 32'd16, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd2, 10'd5, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd3, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd12, 10'd14, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_FORBID_GU, 32'd1, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd12, 10'd14, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd14, 10'd15, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd1023, 10'd0, 4'd0, 3'd0, TYPED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_LOAD_COVARI, 10'd2, 10'd11, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_COVARI_CNT, 32'd1, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd2, 10'd11, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd2, 10'd5, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd4, 10'd13, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_ALLOW_PK, 32'd1, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd4, 10'd13, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd11, 10'd14, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_LOAD_FORBID, 10'd5, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_FORBID_CNT, 32'd1, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd3, 10'd5, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_COVARI_CNT, 32'd31, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd2, 10'd11, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_LOAD_COVARI, 10'd1023, 10'd1023, 4'd15, 3'd0,
			PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd2, 10'd11, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_LOAD_FORBID, 10'd1023, 10'd0, 4'd15, 3'd0,
			PRED, 1'b0},
		'{ROW_CFG, REG_FORBID_CNT, 32'd31, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_LOAD_BASE, 10'd1023, 10'd0, 4'd0, 3'd7, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd13, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_MIN_DIST, 32'd1023, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd1023, 4'd0, 3'd0, TYPED, 1'b0},
		'{ROW_CFG, REG_MAX_DIST, 32'd0, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd3, 10'd4, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_ITEM, REG_MIN_DIST, 32'd0, OP_QUERY, 10'd3, 10'd5, 4'd0, 3'd0, TYPED, 1'b0},
		'{ROW_CFG, REG_MAX_DIST, 32'd1023, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_ALLOW_PK, 32'd0, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0},
		'{ROW_CFG, REG_FORBID_GU, 32'd0, OP_QUERY, 10'd0, 10'd0, 4'd0, 3'd0, PRED, 1'b0}
	};

	function automatic logic pair_rule(logic [BASE_W-1:0] o, logic [BASE_W-1:0] c,
			logic no_gu);
		case ({o, c})
			{BASE_A, BASE_U}, {BASE_U, BASE_A}, {BASE_C, BASE_G}, {BASE_G, BASE_C}:
				return 1'b1;
			{BASE_G, BASE_U}, {BASE_U, BASE_G}:
				return !no_gu;
			default:
				return 1'b0;
		endcase
	endfunction

	function automatic logic predict_pair(logic [POS_W-1:0] row, logic [POS_W-1:0] col);
		int r, c, lb, ub, n, i, o, cl, lo, hi;
		bit r_in, r_out, c_in, c_out;
		r = int'(row);
		c = int'(col);
		lb = r + int'(cfg_shadow.min_pair_dist) + 1;
		ub = r + int'(cfg_shadow.max_pair_dist) + 2;
		if (ub > int'(cfg_shadow.seq_length))
			ub = int'(cfg_shadow.seq_length);
		if (c < lb || c >= ub)
			return 1'b0;
		n = int'(cfg_shadow.covari_count);
		if (n > MAX_COVARI_DEF)
			n = MAX_COVARI_DEF;
		// The last covariation entry has the final say, so scan downward.
		for (i = n - 1; i >= 0; i--) begin
			o = int'(cov_open_mem[i]);
			cl = int'(cov_close_mem[i]);
			if (r == o && c == cl)
				return 1'b1;
			if (r == o || c == cl || r == cl || c == o)
				return 1'b0;
			if (!cfg_shadow.allow_pseudoknot) begin
				lo = (o < cl) ? o : cl;
				hi = (o < cl) ? cl : o;
				r_in = (r > lo && r < hi);
				r_out = (r < lo || r > hi);
				c_in = (c > lo && c < hi);
				c_out = (c < lo || c > hi);
				if ((r_out && c_in) || (r_in && c_out))
					return 1'b0;
			end
		end
		n = int'(cfg_shadow.forbid_count);
		if (n > MAX_FORBID_DEF)
			n = MAX_FORBID_DEF;
		for (i = 0; i < n; i++) begin
			if (r == int'(forbid_mem[i]) || c == int'(forbid_mem[i]))
				return 1'b0;
		end
		return pair_rule(base_mem[r], base_mem[c], cfg_shadow.forbid_gu);
	endfunction

	function automatic logic [31:0] reg_mask(reg_idx_t idx);
		case (idx)
			REG_MIN_DIST, REG_MAX_DIST: return 32'h3FF;
			REG_SEQ_LEN:                return 32'h7FF;
			REG_FORBID_GU, REG_ALLOW_PK: return 32'h1;
			default:                    return 32'h1F;
		endcase
	endfunction

	function automatic int unsigned pick_gap(bit calm);
		int unsigned r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [BASE_W-1:0] rand_base();
		if ($urandom_range(0, 4) == 0)
			return BASE_W'($urandom_range(4, 7));
		return BASE_W'($urandom_range(0, 3));
	endfunction

	// Offers one item and returns at the edge where the transfer takes place.
	task automatic send_item(op_t o, logic [POS_W-1:0] p, logic [POS_W-1:0] q,
			logic [SLOT_W-1:0] s, logic [BASE_W-1:0] b, bit typed, bit texp);
		logic answer;
		start <= 1'b1;
		offering = 1'b1;
		op <= o;
		position <= p;
		partner <= q;
		slot <= s;
		base <= b;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		case (o)
			OP_LOAD_BASE: begin
				base_mem[p] = b;
				n_loads++;
			end
			OP_LOAD_COVARI: begin
				cov_open_mem[s] = p;
				cov_close_mem[s] = q;
				n_loads++;
			end
			OP_LOAD_FORBID: begin
				forbid_mem[s] = p;
				n_loads++;
			end
			default: begin
				answer = typed ? texp : predict_pair(p, q);
				pair_expect_q.push_back(answer);
				n_queries++;
				if (answer)
					n_ones++;
			end
		endcase
	endtask

	task automatic idle_for(int unsigned n);
		if (n > 0) begin
			if (offering) begin
				start <= 1'b0;
				offering = 1'b0;
			end
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops offering items and waits until every query has been answered.
	task automatic wait_results();
		if (offering) begin
			start <= 1'b0;
			offering = 1'b0;
		end
		@(posedge clk);
		while (pair_expect_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		logic [31:0] masked;
		masked = v & reg_mask(idx);
		wait_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= v;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		case (idx)
			REG_MIN_DIST:   cfg_shadow.min_pair_dist = masked[POS_W-1:0];
			REG_MAX_DIST:   cfg_shadow.max_pair_dist = masked[POS_W-1:0];
			REG_SEQ_LEN:    cfg_shadow.seq_length = masked[LEN_CFG_W-1:0];
			REG_FORBID_GU:  cfg_shadow.forbid_gu = masked[0];
			REG_ALLOW_PK:   cfg_shadow.allow_pseudoknot = masked[0];
			REG_COVARI_CNT: cfg_shadow.covari_count = masked[CNT_CFG_W-1:0];
			default:        cfg_shadow.forbid_count = masked[CNT_CFG_W-1:0];
		endcase
		n_writes++;
		// Read the register straight back; psel stays high into the next setup.
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
		if (prdata !== masked) begin
			$error("prdata mismatch for register %s: expected %0d, actual %0d",
				idx.name(), masked, prdata);
			err_cnt++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic send_covari_pair(logic [SLOT_W-1:0] s);
		int o, c, t;
		o = $urandom_range(0, cur_lr - 1);
		c = o + cur_min + 1 + $urandom_range(0, 12);
		if (c > cur_lr - 1)
			c = $urandom_range(0, cur_lr - 1);
		if ($urandom_range(0, 6) == 0) begin
			t = o;
			o = c;
			c = t;
		end
		if ($urandom_range(0, 9) == 0)
			c = $urandom_range(0, 1023);
		send_item(OP_LOAD_COVARI, POS_W'(o), POS_W'(c), s, rand_base(), PRED, 1'b0);
	endtask

	task automatic send_forbid_pos(logic [SLOT_W-1:0] s);
		int p;
		p = $urandom_range(0, cur_lr - 1);
		if ($urandom_range(0, 9) == 0)
			p = $urandom_range(0, 1023);
		send_item(OP_LOAD_FORBID, POS_W'(p), POS_W'($urandom_range(0, 1023)), s,
			rand_base(), PRED, 1'b0);
	endtask

	task automatic send_query();
		int row, col, k, r, ncov, nforb;
		ncov = int'(cfg_shadow.covari_count);
		if (ncov > MAX_COVARI_DEF)
			ncov = MAX_COVARI_DEF;
		nforb = int'(cfg_shadow.forbid_count);
		if (nforb > MAX_FORBID_DEF)
			nforb = MAX_FORBID_DEF;
		r = $urandom_range(0, 99);
		// Default shape: a column just inside the near edge of the window.
		row = $urandom_range(0, cur_lr - 1);
		col = row + cur_min + 1 + $urandom_range(0, 4);
		if (r >= 35 && r < 55 && ncov > 0) begin
			k = $urandom_range(0, ncov - 1);
			row = int'(cov_open_mem[k]);
			col = int'(cov_close_mem[k]);
			case ($urandom_range(0, 3))
				2: begin
					row = int'(cov_close_mem[k]);
					col = int'(cov_open_mem[k]);
				end
				3: col = row + cur_min + 1;
				default: ;
			endcase
		end else if (r >= 55 && r < 65 && nforb > 0) begin
			k = $urandom_range(0, nforb - 1);
			if ($urandom_range(0, 1) == 0) begin
				row = int'(forbid_mem[k]);
				col = row + cur_min + 1 + $urandom_range(0, 2);
			end else begin
				col = int'(forbid_mem[k]);
				row = col - cur_min - 1 - $urandom_range(0, 2);
			end
		end else if (r >= 65 && r < 85) begin
			row = $urandom_range(0, cur_lr - 1);
			col = $urandom_range(0, cur_lr - 1);
		end else if (r >= 85) begin
			row = $urandom_range(0, 1023);
			col = $urandom_range(0, 1023);
		end
		if (row < 0)
			row = 0;
		send_item(OP_QUERY, POS_W'(row), POS_W'(col), SLOT_W'($urandom_range(0, 15)),
			BASE_W'($urandom_range(0, 7)), PRED, 1'b0);
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Every answer must match the oldest outstanding query.
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done === 1'b1) begin
			if (pair_expect_q.size() == 0) begin
				$error("can_pair result %0b arrived with no query outstanding", can_pair);
				err_cnt++;
			end else begin
				oldest_pair = pair_expect_q.pop_front();
				if (can_pair !== oldest_pair) begin
					$error("can_pair mismatch: expected %0b, actual %0b", oldest_pair, can_pair);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done || (psel && penable))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$error("no transfer for %0d cycles", stall_cycles);
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin
		int ph, k, len, mx, r, ncov, nforb;
		bit gu, pk, calm;
		int cc, fc;
		arst_n <= 1'b0;
		start <= 1'b0;
		op <= OP_LOAD_BASE;
		position <= '0;
		partner <= '0;
		slot <= '0;
		base <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		offering = 1'b0;
		err_cnt = 0;
		stall_cycles = 0;
		n_loads = 0;
		n_queries = 0;
		n_ones = 0;
		n_writes = 0;
		cfg_shadow = '{min_pair_dist: 10'd3, max_pair_dist: 10'd1023, seq_length: 11'd0,
			forbid_gu: 1'b0, allow_pseudoknot: 1'b0, covari_count: 5'd0, forbid_count: 5'd0};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Give the memories defined contents before any count or length lets a query read them.
		for (k = 0; k < 16; k++)
			send_item(OP_LOAD_BASE, POS_W'(k), '0, '0, SEED_BASES[k], PRED, 1'b0);
		loaded_len = 16;
		for (k = 0; k < MAX_COVARI_DEF; k++)
			send_item(OP_LOAD_COVARI, POS_W'($urandom_range(0, 1023)),
				POS_W'($urandom_range(0, 1023)), SLOT_W'(k), '0, PRED, 1'b0);
		for (k = 0; k < MAX_FORBID_DEF; k++)
			send_item(OP_LOAD_FORBID, POS_W'($urandom_range(200, 1023)), '0, SLOT_W'(k), '0,
				PRED, 1'b0);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				write_reg(dir_tab[i].idx, dir_tab[i].val);
			end else begin
				send_item(dir_tab[i].opc, dir_tab[i].pos, dir_tab[i].par, dir_tab[i].slt,
					dir_tab[i].bse, dir_tab[i].typed, dir_tab[i].texp);
				idle_for(pick_gap(1'b0));
			end
		end

		for (ph = 0; ph < N_PHASES; ph++) begin
			cur_min = $urandom_range(0, 6);
			mx = ($urandom_range(0, 2) == 0) ? 1023 : $urandom_range(0, 60);
			len = $urandom_range(8, 96);
			gu = 1'($urandom_range(0, 1));
			pk = 1'($urandom_range(0, 1));
			cc = $urandom_range(0, 5);
			fc = $urandom_range(0, 3);
			case (ph)
				0: begin
					cur_min = 0; mx = 0; len = 24; gu = 1'b0; pk = 1'b0; cc = 1; fc = 0;
				end
				1: begin
					cur_min = 1023; mx = 1023; len = 64; gu = 1'b1; pk = 1'b1; cc = 3; fc = 2;
				end
				2: begin
					cur_min = 2; mx = 30; len = 64; gu = 1'b1; pk = 1'b1; cc = 16; fc = 16;
				end
				3: begin
					cur_min = 0; mx = 1023; len = 1024; gu = 1'b0; pk = 1'b0; cc = 4; fc = 31;
				end
				4: len = 2047;
				default: ;
			endcase
			cur_lr = (len > MAX_LENGTH_DEF) ? MAX_LENGTH_DEF : len;
			calm = (ph % 3 == 1);

			while (loaded_len < cur_lr) begin
				send_item(OP_LOAD_BASE, POS_W'(loaded_len), POS_W'($urandom_range(0, 1023)),
					SLOT_W'($urandom_range(0, 15)), rand_base(), PRED, 1'b0);
				loaded_len++;
				idle_for(pick_gap(calm));
			end
			ncov = (cc > MAX_COVARI_DEF) ? MAX_COVARI_DEF : cc;
			nforb = (fc > MAX_FORBID_DEF) ? MAX_FORBID_DEF : fc;
			for (k = 0; k < ncov; k++)
				send_covari_pair(SLOT_W'(k));
			for (k = 0; k < nforb; k++)
				send_forbid_pos(SLOT_W'(k));

			write_reg(REG_MIN_DIST, 32'(cur_min));
			write_reg(REG_MAX_DIST, 32'(mx));
			write_reg(REG_SEQ_LEN, 32'(len));
			write_reg(REG_FORBID_GU, 32'(gu));
			write_reg(REG_ALLOW_PK, 32'(pk));
			write_reg(REG_COVARI_CNT, 32'(cc));
			write_reg(REG_FORBID_CNT, 32'(fc));

			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if ($urandom_range(0, 49) == 0)
					wait_results();
				r = $urandom_range(0, 99);
				if (r < 14)
					send_item(OP_LOAD_BASE,
						($urandom_range(0, 4) == 0) ? POS_W'($urandom_range(0, 1023)) :
							POS_W'($urandom_range(0, cur_lr - 1)),
						POS_W'($urandom_range(0, 1023)), SLOT_W'($urandom_range(0, 15)),
						rand_base(), PRED, 1'b0);
				else if (r < 22)
					send_covari_pair(SLOT_W'($urandom_range(0, 15)));
				else if (r < 27)
					send_forbid_pos(SLOT_W'($urandom_range(0, 15)));
				else
					send_query();
				idle_for(pick_gap(calm));
			end
		end

		wait_results();
		repeat (END_WAIT) @(posedge clk);
		$display("Covered %0d register phases with %0d register writes and %0d list and base loads.",
			N_PHASES, n_writes, n_loads);
		$display("Sent %0d queries, %0d of them expected to allow a pair.", n_queries, n_ones);
		if (err_cnt == 0 && pair_expect_q.size() == 0) begin
			$display("CHECK OK");
		end else begin
			if (pair_expect_q.size() != 0)
				$error("%0d queries never answered", pair_expect_q.size());
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule

/* filelist.f */
src/rpcc_pkg.sv
src/rpcc_cfg_regs.sv
src/rpcc_base_mem.sv
src/rpcc_list_scan.sv
src/rna_pair_constraint_check_top.sv
tb/tb_rna_pair_constraint_check_top.sv
